// ----- rtl/core/wah_bitmap_encoder_core_macros.svh -----
// ----------------------------------------------------------------------------
// WAH bitmap encoder assertion macros
// Concurrent assertion shorthands shared by the encoder modules.
// ----------------------------------------------------------------------------
`ifndef WAH_BITMAP_ENCODER_CORE_MACROS_SVH
`define WAH_BITMAP_ENCODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, idle while reset is low.
`define WBE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, idle while reset is low.
`define WBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WBE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`define WBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/wbe_pkg.sv -----
// ----------------------------------------------------------------------------
// WAH bitmap encoder package
// Widths, item types, command format and state encodings of the encoder.
// ----------------------------------------------------------------------------
package wbe_pkg;

    localparam int GROUP_BITS_DEF = 63;
    localparam int POS_BITS       = 63;
    localparam int WORD_BITS      = 64;
    localparam int COUNT_BITS     = 62;
    localparam int OFF_BITS       = 6;
    localparam int REM_BITS       = 6;
    localparam int MUL_BITS       = 32;
    localparam int CMD_DEPTH_DEF  = 2;
    localparam int RES_DEPTH_DEF  = 4;

    typedef struct packed {
        logic [POS_BITS-1:0] position;
        logic                final_item;
    } t_in_item;

    typedef struct packed {
        logic [WORD_BITS-1:0] code_word;
        logic                 run_end;
    } t_out_item;

    // first: no set open; orbit: lands in or behind the open group; next: lands past it
    typedef enum logic [1:0] {
        CMD_FIRST,
        CMD_ORBIT,
        CMD_NEXT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic                  final_item;
        logic                  bit_ok;
        logic [OFF_BITS-1:0]   offset;
        logic [COUNT_BITS-1:0] gap;
    } t_cmd;

    typedef enum logic {
        FS_CLASSIFY,
        FS_DIVIDE
    } t_front_state;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_CLOSE_NEXT,
        BS_ZFILL,
        BS_CLOSE_FIN,
        BS_FLUSH
    } t_back_state;

endpackage

// ----- rtl/core/wbe_queue.sv -----
// ----------------------------------------------------------------------------
// WAH bitmap encoder queue
// Small first-word-fall-through queue of register entries.
// ----------------------------------------------------------------------------
`include "wah_bitmap_encoder_core_macros.svh"

module wbe_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `WBE_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL, "queue count past depth")

endmodule

// ----- rtl/core/wbe_div.sv -----
// ----------------------------------------------------------------------------
// WAH bitmap encoder group divider
// Splits an offset into whole groups and a remainder by reciprocal multiply.
// ----------------------------------------------------------------------------
module wbe_div #(
    parameter int GROUP_BITS = wbe_pkg::GROUP_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wbe_pkg::POS_BITS-1:0]  i_dividend,
    output logic                          o_busy,
    output logic [wbe_pkg::POS_BITS-1:0]  o_quotient,
    output logic [wbe_pkg::REM_BITS-1:0]  o_remainder
);

    localparam int MB    = wbe_pkg::MUL_BITS;
    localparam int PW    = wbe_pkg::POS_BITS;
    localparam int RW    = wbe_pkg::REM_BITS;
    localparam int ACC_W = 4 * MB;
    localparam int CNT_W = 3;

    typedef logic [2*MB-1:0]  t_prod;
    typedef logic [ACC_W-1:0] t_acc;
    typedef logic [RW:0]      t_low;
    typedef logic [2*RW+1:0]  t_low_prod;

    // Step codes: four partial products, then the correction.
    localparam logic [CNT_W-1:0] ST_LL  = CNT_W'(5);
    localparam logic [CNT_W-1:0] ST_LH  = CNT_W'(4);
    localparam logic [CNT_W-1:0] ST_HL  = CNT_W'(3);
    localparam logic [CNT_W-1:0] ST_HH  = CNT_W'(2);
    localparam logic [CNT_W-1:0] ST_FIX = CNT_W'(1);

    // floor(2^63 / G): the estimate is never high and at most one low.
    localparam t_prod         RECIP    = (t_prod'(1) << PW) / t_prod'(GROUP_BITS);
    localparam logic [MB-1:0] RECIP_LO = RECIP[MB-1:0];
    localparam logic [MB-1:0] RECIP_HI = RECIP[2*MB-1:MB];
    localparam t_low          G_LOW    = t_low'(GROUP_BITS);
    localparam logic [PW-1:0] QUO_ONE  = PW'(1);

    logic [CNT_W-1:0] r_cnt;
    logic [PW-1:0]    r_x;
    t_acc             r_acc, n_acc;
    logic [PW-1:0]    r_quo, n_quo;
    logic [RW-1:0]    r_rem, n_rem;

    logic [MB-1:0]    x_lo;
    logic [MB-1:0]    x_hi;
    logic [MB-1:0]    mul_a;
    logic [MB-1:0]    mul_b;
    t_prod            mul_p;
    logic [PW-1:0]    q_est;
    t_low_prod        qg_low;
    t_low             rem_low;

    assign o_busy      = (r_cnt != '0);
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    assign x_lo    = r_x[MB-1:0];
    assign x_hi    = MB'(r_x[PW-1:MB]);
    assign mul_p   = t_prod'(mul_a) * t_prod'(mul_b);
    assign q_est   = r_acc[PW +: PW];
    // The true remainder is below 2G, so the low bits of the difference do.
    assign qg_low  = t_low_prod'(q_est[RW:0]) * t_low_prod'(G_LOW);
    assign rem_low = r_x[RW:0] - qg_low[RW:0];

    always_comb begin : p_operands
        mul_a = x_lo;
        mul_b = RECIP_LO;
        if (r_cnt == ST_HL || r_cnt == ST_HH) begin
            mul_a = x_hi;
        end
        if (r_cnt == ST_LH || r_cnt == ST_HH) begin
            mul_b = RECIP_HI;
        end
    end

    // Accumulate one 32x32 partial product a cycle, then correct the estimate.
    always_comb begin : p_step
        n_acc = r_acc;
        n_quo = r_quo;
        n_rem = r_rem;
        unique case (r_cnt)
            ST_LL: begin
                n_acc = r_acc + t_acc'(mul_p);
            end
            ST_LH, ST_HL: begin
                n_acc = r_acc + (t_acc'(mul_p) << MB);
            end
            ST_HH: begin
                n_acc = r_acc + (t_acc'(mul_p) << (2 * MB));
            end
            ST_FIX: begin
                if (rem_low >= G_LOW) begin
                    n_quo = q_est + QUO_ONE;
                    n_rem = RW'(rem_low - G_LOW);
                end else begin
                    n_quo = q_est;
                    n_rem = rem_low[RW-1:0];
                end
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= ST_LL;
        end else if (o_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_dividend;
            r_acc <= '0;
        end else if (o_busy) begin
            r_acc <= n_acc;
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

endmodule

// ----- rtl/core/wbe_front.sv -----
// ----------------------------------------------------------------------------
// WAH bitmap encoder front end
// Takes positions, tracks the open group and issues encode commands.
// ----------------------------------------------------------------------------
`include "wah_bitmap_encoder_core_macros.svh"

module wbe_front #(
    parameter int GROUP_BITS = wbe_pkg::GROUP_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wbe_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_cmd_push,
    output wbe_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_full
);

    typedef logic [wbe_pkg::WORD_BITS:0]   t_diff;
    typedef logic [wbe_pkg::WORD_BITS-1:0] t_word;
    typedef logic [wbe_pkg::POS_BITS-1:0]  t_pos;
    typedef logic [wbe_pkg::OFF_BITS-1:0]  t_off;

    localparam t_diff G_DIFF = t_diff'(GROUP_BITS);
    localparam t_word G_WORD = t_word'(GROUP_BITS);
    localparam t_pos  G_POS  = t_pos'(GROUP_BITS);
    localparam t_off  G_LAST = t_off'(GROUP_BITS - 1);
    localparam t_word G_END0 = t_word'(GROUP_BITS - 1);

    wbe_pkg::t_front_state r_state, n_state;
    logic                  r_hold_valid, n_hold_valid;
    logic                  r_started, n_started;
    t_word                 r_group_end, n_group_end;
    t_pos                  r_pos;
    logic                  r_fin;

    t_diff                        ge_minus_p;
    t_pos                         dividend;
    logic                         is_orbit;
    logic                         is_fast;
    logic                         in_range;
    t_off                         fast_off;
    t_off                         slow_off;
    t_word                        fast_ge;
    t_word                        slow_ge;
    t_word                        new_ge;
    logic                         release_item;
    logic                         accept;
    logic                         div_start;
    logic                         div_busy;
    t_pos                         div_quo;
    logic [wbe_pkg::REM_BITS-1:0] div_rem;

    wbe_div #(
        .GROUP_BITS (GROUP_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (dividend),
        .o_busy      (div_busy),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Negative difference means the position lies past the open group; its
    // complement is then the distance past the group end, less one.
    assign ge_minus_p = {1'b0, r_group_end} - {2'b00, r_pos};
    assign dividend   = r_started ? ~ge_minus_p[wbe_pkg::POS_BITS-1:0] : r_pos;
    assign is_orbit   = r_started && !ge_minus_p[wbe_pkg::WORD_BITS];
    assign in_range   = (ge_minus_p < G_DIFF);
    assign is_fast    = is_orbit || (dividend < G_POS);
    assign fast_off   = is_orbit ? ge_minus_p[wbe_pkg::OFF_BITS-1:0]
                                 : G_LAST - dividend[wbe_pkg::OFF_BITS-1:0];
    assign slow_off   = G_LAST - div_rem;
    assign fast_ge    = (is_orbit || !r_started) ? r_group_end : r_group_end + G_WORD;
    assign slow_ge    = {1'b0, r_pos} + t_word'(slow_off);

    assign o_full = r_hold_valid && !release_item;
    assign accept = i_push && !o_full;

    always_comb begin
        n_state      = r_state;
        n_started    = r_started;
        n_group_end  = r_group_end;
        release_item = 1'b0;
        div_start    = 1'b0;
        o_cmd_push   = 1'b0;
        new_ge       = fast_ge;

        o_cmd.kind       = is_orbit ? wbe_pkg::CMD_ORBIT
                         : (r_started ? wbe_pkg::CMD_NEXT : wbe_pkg::CMD_FIRST);
        o_cmd.final_item = r_fin;
        o_cmd.bit_ok     = is_orbit && in_range;
        o_cmd.offset     = fast_off;
        o_cmd.gap        = '0;

        unique case (r_state)
            wbe_pkg::FS_CLASSIFY: begin
                if (r_hold_valid) begin
                    if (is_fast) begin
                        if (!i_cmd_full) begin
                            o_cmd_push   = 1'b1;
                            release_item = 1'b1;
                        end
                    end else begin
                        div_start = 1'b1;
                        n_state   = wbe_pkg::FS_DIVIDE;
                    end
                end
            end
            wbe_pkg::FS_DIVIDE: begin
                o_cmd.offset = slow_off;
                o_cmd.gap    = div_quo[wbe_pkg::COUNT_BITS-1:0];
                new_ge       = slow_ge;
                if (!div_busy && !i_cmd_full) begin
                    o_cmd_push   = 1'b1;
                    release_item = 1'b1;
                    n_state      = wbe_pkg::FS_CLASSIFY;
                end
            end
            default: begin
                n_state = wbe_pkg::FS_CLASSIFY;
            end
        endcase

        // Drop back to the reset group after the final item of a set.
        if (release_item) begin
            n_started   = !r_fin;
            n_group_end = r_fin ? G_END0 : new_ge;
        end

        n_hold_valid = accept || (r_hold_valid && !release_item);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= wbe_pkg::FS_CLASSIFY;
            r_hold_valid <= 1'b0;
            r_started    <= 1'b0;
            r_group_end  <= G_END0;
        end else begin
            r_state      <= n_state;
            r_hold_valid <= n_hold_valid;
            r_started    <= n_started;
            r_group_end  <= n_group_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos <= i_item.position;
            r_fin <= i_item.final_item;
        end
    end

    `WBE_ASSERT_NEXT(a_div_runs, i_clk, i_rst_n, div_start, div_busy, "divider not busy after start")
    `WBE_ASSERT_IMPLY(a_div_holds, i_clk, i_rst_n, r_state == wbe_pkg::FS_DIVIDE, r_hold_valid, "dividing with no item held")

endmodule

// ----- rtl/core/wbe_back.sv -----
// ----------------------------------------------------------------------------
// WAH bitmap encoder back end
// Builds the open literal, merges one-fills and emits code words.
// ----------------------------------------------------------------------------
`include "wah_bitmap_encoder_core_macros.svh"

module wbe_back #(
    parameter int GROUP_BITS = wbe_pkg::GROUP_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  wbe_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output wbe_pkg::t_out_item o_res
);

    typedef logic [GROUP_BITS-1:0]             t_lit;
    typedef logic [wbe_pkg::COUNT_BITS-1:0]    t_count;
    typedef logic [wbe_pkg::WORD_BITS-1:0]     t_word;

    localparam t_lit       LIT_ONE    = t_lit'(1);
    localparam t_lit       LIT_ONES   = '1;
    localparam t_count     COUNT_MAX  = '1;
    localparam logic [1:0] FILL_ONES  = 2'b11;
    localparam logic [1:0] FILL_ZEROS = 2'b10;

    wbe_pkg::t_back_state r_state, n_state;
    t_lit                 r_lit, n_lit;
    t_count               r_held, n_held;
    wbe_pkg::t_cmd        r_cmd, n_cmd;

    logic  step_en;
    logic  lit_ones;
    logic  held_nz;
    logic  held_max;
    logic  close_done;
    t_lit  head_bit;
    t_lit  cmd_bit;
    t_word ones_word;
    t_word lit_word;
    t_word zf_word;

    assign step_en   = !i_res_full;
    assign lit_ones  = (r_lit == LIT_ONES);
    assign held_nz   = (r_held != '0);
    assign held_max  = (r_held == COUNT_MAX);
    assign head_bit  = LIT_ONE << i_cmd.offset;
    assign cmd_bit   = LIT_ONE << r_cmd.offset;
    assign ones_word = {FILL_ONES, r_held};
    assign lit_word  = t_word'(r_lit);
    assign zf_word   = {FILL_ZEROS, r_cmd.gap};

    always_comb begin
        n_state         = r_state;
        n_lit           = r_lit;
        n_held          = r_held;
        n_cmd           = r_cmd;
        close_done      = 1'b0;
        o_cmd_pop       = 1'b0;
        o_res_push      = 1'b0;
        o_res.code_word = ones_word;
        o_res.run_end   = 1'b0;

        if (step_en) begin
            unique case (r_state)
                wbe_pkg::BS_IDLE: begin
                    if (i_cmd_valid) begin
                        o_cmd_pop = 1'b1;
                        n_cmd     = i_cmd;
                        unique case (i_cmd.kind)
                            wbe_pkg::CMD_FIRST: begin
                                if (i_cmd.gap != '0) begin
                                    n_state = wbe_pkg::BS_ZFILL;
                                end else begin
                                    n_lit   = head_bit;
                                    n_state = i_cmd.final_item ? wbe_pkg::BS_CLOSE_FIN
                                                               : wbe_pkg::BS_IDLE;
                                end
                            end
                            wbe_pkg::CMD_ORBIT: begin
                                if (i_cmd.bit_ok) begin
                                    n_lit = r_lit | head_bit;
                                end
                                n_state = i_cmd.final_item ? wbe_pkg::BS_CLOSE_FIN
                                                           : wbe_pkg::BS_IDLE;
                            end
                            wbe_pkg::CMD_NEXT: begin
                                n_state = wbe_pkg::BS_CLOSE_NEXT;
                            end
                            default: begin
                                n_state = wbe_pkg::BS_IDLE;
                            end
                        endcase
                    end
                end
                wbe_pkg::BS_CLOSE_NEXT, wbe_pkg::BS_CLOSE_FIN: begin
                    // Merge an all-ones literal, else flush the held fill first.
                    if (lit_ones) begin
                        close_done = 1'b1;
                        if (held_nz && !held_max) begin
                            n_held = r_held + t_count'(1);
                        end else begin
                            o_res_push = held_nz;
                            n_held     = t_count'(1);
                        end
                    end else if (held_nz) begin
                        o_res_push = 1'b1;
                        n_held     = '0;
                    end else begin
                        o_res_push      = 1'b1;
                        o_res.code_word = lit_word;
                        o_res.run_end   = (r_state == wbe_pkg::BS_CLOSE_FIN);
                        close_done      = 1'b1;
                    end
                    if (close_done) begin
                        if (r_state == wbe_pkg::BS_CLOSE_FIN) begin
                            if (lit_ones) begin
                                n_state = wbe_pkg::BS_FLUSH;
                            end else begin
                                n_lit   = '0;
                                n_state = wbe_pkg::BS_IDLE;
                            end
                        end else if (r_cmd.gap != '0) begin
                            n_state = wbe_pkg::BS_ZFILL;
                        end else begin
                            n_lit   = cmd_bit;
                            n_state = r_cmd.final_item ? wbe_pkg::BS_CLOSE_FIN
                                                       : wbe_pkg::BS_IDLE;
                        end
                    end
                end
                wbe_pkg::BS_ZFILL: begin
                    o_res_push = 1'b1;
                    if (held_nz) begin
                        n_held = '0;
                    end else begin
                        o_res.code_word = zf_word;
                        n_lit           = cmd_bit;
                        n_state         = r_cmd.final_item ? wbe_pkg::BS_CLOSE_FIN
                                                           : wbe_pkg::BS_IDLE;
                    end
                end
                wbe_pkg::BS_FLUSH: begin
                    o_res_push    = held_nz;
                    o_res.run_end = 1'b1;
                    n_held        = '0;
                    n_lit         = '0;
                    n_state       = wbe_pkg::BS_IDLE;
                end
                default: begin
                    n_state = wbe_pkg::BS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wbe_pkg::BS_IDLE;
            r_lit   <= '0;
            r_held  <= '0;
        end else begin
            r_state <= n_state;
            r_lit   <= n_lit;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    `WBE_ASSERT_IMPLY(a_flush_held, i_clk, i_rst_n, r_state == wbe_pkg::BS_FLUSH, held_nz, "flush with no one-fill held")
    `WBE_ASSERT_IMPLY(a_push_room, i_clk, i_rst_n, o_res_push, !i_res_full, "word emitted into full queue")

endmodule

// ----- rtl/core/wah_bitmap_encoder_core.sv -----
// ----------------------------------------------------------------------------
// WAH bitmap encoder core
// Encodes increasing set-bit positions into 64-bit word-aligned-hybrid words.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload                         direction
//  --------  -------------------  ------------------------------  ---------
//  input     push / full          i_item  (position, final_item)  in
//  result    empty / pop          o_result (code_word, run_end)   out
//
// Rate: an item inside the open group streams at one per cycle while the
// command queue has room. The back takes a command, then emits up to 4
// words for it in turn. A jump past empty groups holds the front to divide.
// Reset: synchronous, active low; clears every control register at once.
// Stalls: full is high while the front divides or the command queue is full;
// the back halts on a full result queue, which backs up into the front.
//
module wah_bitmap_encoder_core #(
    parameter int GROUP_BITS = wbe_pkg::GROUP_BITS_DEF,
    parameter int CMD_DEPTH  = wbe_pkg::CMD_DEPTH_DEF,
    parameter int RES_DEPTH  = wbe_pkg::RES_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  wbe_pkg::t_in_item  i_item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output wbe_pkg::t_out_item o_result
);

    localparam int CMD_W = $bits(wbe_pkg::t_cmd);
    localparam int RES_W = $bits(wbe_pkg::t_out_item);

    // front to back command queue
    logic               cmd_push;
    wbe_pkg::t_cmd      cmd_in;
    logic               cmd_full;
    logic               cmd_pop;
    wbe_pkg::t_cmd      cmd_head;
    logic               cmd_empty;

    // back to result queue
    logic               res_push;
    wbe_pkg::t_out_item res_in;
    logic               res_full;

    // Front: hold one position, classify it against the open group and
    // divide long gaps into whole empty groups.
    wbe_front #(
        .GROUP_BITS (GROUP_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    // Decouple classification from word emission so either side can stall.
    wbe_queue #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty)
    );

    // Back: own the literal and the held one-fill, emit at most one word a cycle while the result queue has room.
    wbe_back #(
        .GROUP_BITS (GROUP_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // Result queue: the oldest word sits on o_result while empty is low.
    wbe_queue #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

// ----- test/wbe_word_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAH encoder word checker
// Watches both channels of the encoder, predicts the code words of every
// accepted item and compares each popped word against the oldest prediction.
// ----------------------------------------------------------------------------
module wbe_word_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  wbe_pkg::t_in_item  i_item,
    input  logic               i_empty,
    input  logic               i_pop,
    input  wbe_pkg::t_out_item i_result,
    output int                 o_fail_count,
    output int                 o_words_due
);
    import wbe_pkg::*;

    localparam logic [63:0] GRP       = 64'(GROUP_BITS_DEF);
    localparam logic [63:0] FILL_FLAG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONES_HDR  = 64'hC000_0000_0000_0000;
    localparam logic [63:0] CNT_MASK  = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [63:0] LIT_FULL  = (64'd1 << GROUP_BITS_DEF) - 64'd1;
    localparam int          MAX_WORDS = 4;

    logic        set_open;
    logic [63:0] grp_last;
    logic [63:0] lit_acc;
    logic [61:0] ones_run;
    t_out_item   batch[$];
    t_out_item   pending_words[$];
    int          fails = 0;

    task automatic note_miss(input string what, input logic [63:0] want,
                             input logic [63:0] got);
        fails++;
        $display("%0t: %s mismatch: expected %h actual %h", $realtime, what, want, got);
    endtask

    task automatic put_word(input logic [63:0] w);
        t_out_item word_item;
        word_item.code_word = w;
        word_item.run_end   = 1'b0;
        if (batch.size() < MAX_WORDS)
            batch.insert(batch.size(), word_item);
    endtask

    task automatic release_ones();
        if (ones_run != '0) begin
            put_word(ONES_HDR | {2'b00, ones_run});
            ones_run = '0;
        end
    endtask

    // Close the open group: fold an all-ones literal into the one-fill, else emit it after the held one-fill.
    task automatic retire_literal();
        if (lit_acc == LIT_FULL) begin
            if (ones_run != '0 && ones_run != '1) begin
                ones_run = ones_run + 62'd1;
            end else begin
                release_ones();
                ones_run = 62'd1;
            end
        end else begin
            release_ones();
            put_word(lit_acc);
        end
    endtask

    task automatic clear_state();
        set_open = 1'b0;
        grp_last = GRP - 64'd1;
        lit_acc  = '0;
        ones_run = '0;
    endtask

    task automatic encode_position(input t_in_item it);
        logic [63:0] p;
        logic [63:0] gap;
        t_out_item   tail_word;
        batch.delete();
        p = {1'b0, it.position};
        if (!set_open) begin
            gap = p / GRP;
            if (gap != 0)
                put_word(FILL_FLAG | (gap & CNT_MASK));
            grp_last = (GRP - 64'd1) + GRP * gap;
            lit_acc  = 64'd1 << ((grp_last - p) & 64'd63);
            set_open = 1'b1;
        end else if (p <= grp_last) begin
            // inside the open group or behind it; only the former sets a bit
            if (grp_last - p < GRP)
                lit_acc = lit_acc | (64'd1 << (grp_last - p));
        end else begin
            retire_literal();
            gap = (p - grp_last - 64'd1) / GRP;
            if (gap != 0) begin
                release_ones();
                put_word(FILL_FLAG | (gap & CNT_MASK));
            end
            grp_last = grp_last + (gap + 64'd1) * GRP;
            lit_acc  = 64'd1 << ((grp_last - p) & 64'd63);
        end
        lit_acc = lit_acc & LIT_FULL;
        if (it.final_item) begin
            retire_literal();
            release_ones();
            if (batch.size() > 0) begin
                tail_word = batch[batch.size() - 1];
                tail_word.run_end = 1'b1;
                batch[batch.size() - 1] = tail_word;
            end
            clear_state();
        end
        foreach (batch[k])
            pending_words.insert(pending_words.size(), batch[k]);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_state();
            pending_words.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (pending_words.size() == 0) begin
                    note_miss("unexpected word", '0, i_result.code_word);
                end else begin
                    want = pending_words.pop_front();
                    if (want.code_word !== i_result.code_word)
                        note_miss("code_word", want.code_word, i_result.code_word);
                    if (want.run_end !== i_result.run_end)
                        note_miss("run_end", 64'(want.run_end), 64'(i_result.run_end));
                end
            end
            if (i_push && !i_full)
                encode_position(i_item);
        end
        o_words_due  <= pending_words.size();
        o_fail_count <= fails;
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAH bitmap encoder testbench
// Feeds sets of set-bit positions (sparse, dense all-ones runs, huge gaps,
// repeats and out-of-order noise) under random idling on both sides and a
// long result stall, and reports the verdict of the word checker.
// ----------------------------------------------------------------------------
module tb;
    import wbe_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          RANDOM_ITEMS = 480;
    localparam logic [62:0] POS_MAX      = '1;
    localparam logic [62:0] GRP          = 63'(GROUP_BITS_DEF);
    // keep random set starts far enough below the top that steps never wrap
    localparam logic [62:0] HEADROOM     = 63'd1 << 45;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  i_item  = '0;
    logic      full;
    logic      empty;
    t_out_item o_result;

    int   fail_count;
    int   words_due;
    int   cycles     = 0;
    int   items_sent = 0;
    logic quiet      = 1'b0;   // last part of the run: no idling at all
    logic calm       = 1'b0;   // per-set stretch without idling
    logic hold_req   = 1'b0;
    logic hold_done  = 1'b0;

    wah_bitmap_encoder_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    wbe_word_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (i_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: pop most cycles, drop pop in short bursts, and hold off
    // once for a long stretch so the encoder backs up into its input.
    initial begin : result_side
        int burst;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
                pop <= 1'b0;
                burst = $urandom_range(1, 6);
                repeat (burst) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one item and hold it until the encoder takes it.
    task automatic push_pos(input logic [62:0] pos, input logic fin);
        int gap;
        if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= t_in_item'{position: pos, final_item: fin};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
    endtask

    // Step to the next position: same group, next group, a few groups on,
    // or a huge jump that exercises the group divider.
    function automatic logic [62:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 63'($urandom_range(1, 4));
        else if (r < 80)
            return 63'($urandom_range(20, 130));
        else if (r < 93)
            return 63'($urandom_range(131, 5000));
        else
            return {27'd0, 4'($urandom_range(0, 15)), 32'($urandom)} + 63'd1;
    endfunction

    task automatic sparse_set();
        logic [62:0] pos;
        logic [62:0] back;
        int          n;
        int          k;
        int          r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            pos = 63'($urandom_range(0, 3000));
        end else if (r < 8) begin
            pos = 63'($urandom);
        end else begin
            pos = 63'({$urandom, $urandom});
            if (pos > POS_MAX - HEADROOM)
                pos = POS_MAX - HEADROOM;
        end
        n = $urandom_range(0, 10);
        push_pos(pos, n == 0);
        for (k = 1; k <= n; k++) begin
            if ($urandom_range(0, 99) < 12) begin
                // noise: a repeat or a position behind the open group
                back = 63'($urandom_range(0, 200));
                push_pos((pos > back) ? pos - back : '0, k == n);
            end else begin
                pos = pos + pick_step();
                push_pos(pos, k == n);
            end
        end
    endtask

    // Fill whole groups, then either end on the last bit or open a partial
    // group and end far away, so one item flushes a one-fill, a literal, a
    // zero-fill and the closing literal.
    task automatic dense_set(input int groups, input logic tail);
        logic [62:0] base;
        int          span;
        int          extra;
        int          k;
        base = GRP * 63'($urandom_range(0, 40));
        span = groups * GROUP_BITS_DEF;
        for (k = 0; k < span; k++)
            push_pos(base + 63'(k), !tail && k == span - 1);
        if (tail) begin
            extra = $urandom_range(1, 5);
            for (k = 0; k < extra; k++)
                push_pos(base + 63'(span + 2 * k), 1'b0);
            push_pos(base + 63'(span) + 63'($urandom_range(200, 100000)), 1'b1);
        end
    endtask

    initial begin : stimulus
        int directed_n;
        int set_no;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: lone first and last bits of a group, first group boundary,
        // the top position, repeats, out-of-order bits, a big gap mid-set.
        push_pos(63'd0, 1'b1);
        push_pos(63'd62, 1'b1);
        push_pos(63'd63, 1'b1);
        push_pos(POS_MAX, 1'b1);
        push_pos(63'd5, 1'b0);
        push_pos(63'd5, 1'b0);
        push_pos(63'd10, 1'b0);
        push_pos(63'd70, 1'b0);
        push_pos(63'd2, 1'b0);
        push_pos(63'd200000, 1'b0);
        push_pos(63'd200001, 1'b1);
        push_pos(63'd100, 1'b0);
        push_pos(63'd50, 1'b1);
        push_pos(POS_MAX - 63'd100, 1'b0);
        push_pos(POS_MAX, 1'b1);
        push_pos(63'h5555_AAAA_1234_5678, 1'b0);
        push_pos(63'h5555_AAAA_1234_5678 + GRP, 1'b0);
        push_pos(63'h2AAA_5555_EDCB_A987, 1'b1);
        push_pos(POS_MAX - GRP, 1'b0);
        push_pos(POS_MAX - 63'd1, 1'b0);
        push_pos(63'd0, 1'b1);
        directed_n = items_sent;

        // Random sets; two of them are dense all-ones runs.
        set_no = 0;
        while (items_sent < directed_n + RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            if (set_no == 2)
                dense_set(2, 1'b1);
            else if (set_no == 9)
                dense_set($urandom_range(1, 2), 1'b0);
            else
                sparse_set();
            set_no++;
            if (items_sent >= directed_n + 100)
                hold_req = 1'b1;
            if (items_sent >= directed_n + RANDOM_ITEMS - 60)
                quiet = 1'b1;
        end
        push <= 1'b0;

        // Let the checker's count catch up, wait for every word, then drain.
        @(posedge i_clk);
        while (words_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && words_due == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/wbe_pkg.sv
rtl/core/wbe_queue.sv
rtl/core/wbe_div.sv
rtl/core/wbe_front.sv
rtl/core/wbe_back.sv
rtl/core/wah_bitmap_encoder_core.sv
test/wbe_word_checker.sv
test/tb.sv
